// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg)

`endif

`endif

// ----- src/bst_pkg.sv -----
package bst_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DUP     = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

endpackage

// ----- src/bounded_set_table_core.sv -----
// Bounded set table: keeps up to SET_SIZE distinct 32-bit values in
// insertion order.
// Input channel (in_valid_i / in_stall_o) carries one request beat: cmd_i
// selects insert, delete or membership query, item_value_i the value.
// Output channel (out_valid_o / out_stall_i) returns one result beat per
// request: status, whether the value was present, and the element count.
// A request walks the entry memory one entry per cycle through its single
// read port until a hit or the end of the stored entries; an empty set is
// not read at all. A delete then moves each later entry down one place,
// one per cycle. The result register is loaded last, and one request is
// in work at a time.
// The next request beat is taken as soon as the result register is loaded,
// even while that result still waits on out_stall_i. A stalled result holds
// the block in its last step until the register frees.
// Reset clears the element count and the handshake state; the entry memory
// is not cleared, only entries below the count are ever read.
module bounded_set_table_core #(
  parameter int SET_SIZE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bst_pkg::CMD_W-1:0]    cmd_i,
  input  logic signed [bst_pkg::VALUE_W-1:0] item_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bst_pkg::STAT_W-1:0]   status_o,
  output logic                         was_present_o,
  output logic [bst_pkg::COUNT_W-1:0]  element_count_o
);

  import bst_pkg::*;

`include "assert_macros.svh"

  localparam int AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CW = $clog2(SET_SIZE + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [CW-1:0]      ridx_q, ridx_d;
  logic               rvld_q, rvld_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [STAT_W-1:0]  stat_q, stat_d;
  logic               present_q, present_d;
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;
  logic               out_present_q, out_present_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [VALUE_W-1:0] mem_rdata;
  logic               issue;
  logic               hit;
  logic               in_accept;
  logic [CW-1:0]      ridx_dec;
  logic [XW-1:0]      count_ext;

  bst_store #(
    .DEPTH (SET_SIZE),
    .WIDTH (VALUE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign issue     = (ptr_q < fill_q);
  assign hit       = rvld_q && (mem_rdata == value_q);
  assign ridx_dec  = ridx_q - CW'(1);
  assign count_ext = XW'(fill_q);

  // sequence one request: walk, modify, write back, report
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    ptr_d         = ptr_q;
    ridx_d        = ridx_q;
    rvld_d        = 1'b0;
    cmd_d         = cmd_q;
    value_d       = value_q;
    stat_d        = stat_q;
    present_d     = present_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_stat_d    = out_stat_q;
    out_present_d = out_present_q;
    out_count_d   = out_count_q;
    mem_we        = 1'b0;
    mem_waddr     = fill_q[AW-1:0];
    mem_wdata     = value_q;
    mem_re        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d     = cmd_i;
          value_d   = $unsigned(item_value_i);
          ptr_d     = '0;
          stat_d    = STATUS_OK;
          present_d = 1'b0;
          state_d   = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          present_d = 1'b1;
          state_d   = ST_DONE;
          case (cmd_q)
            CMD_INSERT: stat_d = STATUS_DUP;
            CMD_DELETE: begin
              // close the gap unless the hit is the last entry
              if ((ridx_q + CW'(1)) < fill_q) begin
                ptr_d   = ridx_q + CW'(1);
                state_d = ST_SHIFT;
              end else begin
                fill_d = fill_q - CW'(1);
              end
            end
            default: ;
          endcase
        end else if (!issue && !rvld_q) begin
          // value absent after the whole walk
          state_d = ST_DONE;
          case (cmd_q)
            CMD_INSERT: begin
              if (fill_q < CW'(SET_SIZE)) begin
                mem_we = 1'b1;
                fill_d = fill_q + CW'(1);
              end else begin
                stat_d = STATUS_FULL;
              end
            end
            CMD_DELETE: stat_d = STATUS_MISSING;
            default: ;
          endcase
        end else begin
          // advance the read pointer
          mem_re = issue;
          rvld_d = issue;
          ridx_d = ptr_q;
          if (issue) begin
            ptr_d = ptr_q + CW'(1);
          end
        end
      end

      ST_SHIFT: begin
        // move the entry read last cycle down one place
        if (rvld_q) begin
          mem_we    = 1'b1;
          mem_waddr = ridx_dec[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (issue) begin
          mem_re = 1'b1;
          rvld_d = 1'b1;
          ridx_d = ptr_q;
          ptr_d  = ptr_q + CW'(1);
        end else if (!rvld_q) begin
          fill_d  = fill_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_stat_d    = stat_q;
          out_present_d = present_q;
          out_count_d   = count_ext[COUNT_W-1:0];
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    ptr_q         <= ptr_d;
    ridx_q        <= ridx_d;
    cmd_q         <= cmd_d;
    value_q       <= value_d;
    stat_q        <= stat_d;
    present_q     <= present_d;
    out_stat_q    <= out_stat_d;
    out_present_q <= out_present_d;
    out_count_q   <= out_count_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign was_present_o   = out_present_q;
  assign element_count_o = out_count_q;

  `ASSERT_AT(a_fill_bound, clk_i, rst_ni, fill_q <= CW'(SET_SIZE), "fill count above set size")
  `ASSERT_AT(a_fill_step, clk_i, rst_ni, (fill_q != $past(fill_q)) |-> ((fill_q == ($past(fill_q) + CW'(1))) || ((fill_q + CW'(1)) == $past(fill_q))), "fill count jumped")
  `ASSERT_AT(a_write_busy, clk_i, rst_ni, mem_we |-> ((state_q == ST_SEARCH) || (state_q == ST_SHIFT)), "memory write while idle")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, state_q == ST_SEARCH, "accepted beat did not start a walk")
  `ASSERT_AT(a_shift_delete, clk_i, rst_ni, (state_q == ST_SHIFT) |-> (present_q && (cmd_q == CMD_DELETE)), "compaction without a delete hit")

endmodule

// ----- src/bst_store.sv -----
module bst_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import bst_pkg::*;

  localparam int SET_SIZE       = 16;
  localparam int RANDOM_ITEMS   = 720;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * SET_SIZE + 8;
  localparam int MAX_REPORTS    = 60;
  localparam int NUM_ROWS       = 24;

  // Unused command code; the block answers it like a membership query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    status_e              status;
    logic                 was_present;
    logic [COUNT_W-1:0]   count;
  } set_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]     op;
    logic [VALUE_W-1:0]   value;
    logic [4:0]           reps;
    bit                   typed;
    status_e              status;
    logic                 was_present;
    logic [COUNT_W-1:0]   count;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i        = '0;
  logic [VALUE_W-1:0]   item_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [STAT_W-1:0]    status_o;
  logic                 was_present_o;
  logic [COUNT_W-1:0]   element_count_o;

  logic [VALUE_W-1:0]   set_members[$];
  set_result_t          pending_results[$];
  logic [VALUE_W-1:0]   value_pool[POOL_SIZE];
  int                   error_count = 0;
  int                   idle_cycles = 0;
  int                   burst_left  = 0;

  // Directed rows: a typed result where it is obvious, else the predictor decides.
  // A row with reps above one repeats with the value stepped by one each time.
  stim_row_t directed_rows[NUM_ROWS] = '{
    '{CMD_QUERY,  32'h0000_0000, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd0},
    '{CMD_DELETE, 32'h0000_0005, 5'd1,  1'b1, STATUS_MISSING, 1'b0, 5'd0},
    '{CMD_INSERT, 32'h8000_0000, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd1},
    '{CMD_INSERT, 32'h7fff_ffff, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd2},
    '{CMD_INSERT, 32'h0000_0000, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd3},
    '{CMD_INSERT, 32'hffff_ffff, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd4},
    '{CMD_INSERT, 32'h7fff_ffff, 5'd1,  1'b1, STATUS_DUP,     1'b1, 5'd4},
    '{CMD_QUERY,  32'h8000_0000, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd4},
    '{CMD_SPARE,  32'h0000_0000, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd4},
    '{CMD_SPARE,  32'h1234_5678, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd4},
    '{CMD_QUERY,  32'h5555_5555, 5'd1,  1'b1, STATUS_OK,      1'b0, 5'd4},
    '{CMD_DELETE, 32'h7fff_ffff, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd3},
    '{CMD_DELETE, 32'hffff_ffff, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd2},
    '{CMD_DELETE, 32'h8000_0000, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd1},
    '{CMD_DELETE, 32'h8000_0000, 5'd1,  1'b1, STATUS_MISSING, 1'b0, 5'd1},
    '{CMD_INSERT, 32'haaaa_aaaa, 5'd15, 1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_INSERT, 32'h0000_0000, 5'd1,  1'b1, STATUS_DUP,     1'b1, 5'd16},
    '{CMD_INSERT, 32'h1357_2468, 5'd1,  1'b1, STATUS_FULL,    1'b0, 5'd16},
    '{CMD_QUERY,  32'haaaa_aab8, 5'd1,  1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_DELETE, 32'haaaa_aab8, 5'd1,  1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_DELETE, 32'h0000_0000, 5'd1,  1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_INSERT, 32'h1357_2468, 5'd1,  1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_DELETE, 32'haaaa_aaaa, 5'd15, 1'b0, STATUS_OK,      1'b0, 5'd0},
    '{CMD_DELETE, 32'h1357_2468, 5'd1,  1'b1, STATUS_OK,      1'b1, 5'd0}
  };

  bounded_set_table_core #(
    .SET_SIZE(SET_SIZE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .was_present_o  (was_present_o),
    .element_count_o(element_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the shadow set and return the result it must give.
  function automatic set_result_t apply_to_set(input logic [CMD_W-1:0] op,
                                               input logic [VALUE_W-1:0] value);
    set_result_t res;
    int          pos = -1;
    foreach (set_members[i]) begin
      if (pos < 0 && set_members[i] == value) pos = i;
    end
    res.was_present = (pos >= 0);
    res.status      = STATUS_OK;
    case (op)
      CMD_INSERT: begin
        if (pos >= 0) res.status = STATUS_DUP;
        else if (set_members.size() < SET_SIZE) set_members.push_back(value);
        else res.status = STATUS_FULL;
      end
      CMD_DELETE: begin
        if (pos >= 0) set_members.delete(pos);
        else res.status = STATUS_MISSING;
      end
      default: ;
    endcase
    res.count = COUNT_W'(set_members.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Drive one request beat and hold it until taken, then log what it must return.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] value,
                           input bit typed, input set_result_t typed_result);
    set_result_t predicted;
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    item_value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_to_set(op, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Count down the burst; at its end add a random gap, then pick the next burst length.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Pick a value: when asked, often a current member; else mostly the pool, sometimes anything.
  function automatic logic [VALUE_W-1:0] pick_value(input bit prefer_member);
    if (prefer_member && set_members.size() > 0 && $urandom_range(0, 1) == 1)
      return set_members[$urandom_range(0, set_members.size() - 1)];
    if ($urandom_range(0, 9) < 8)
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Receiver: stall on a pattern that changes mode every window.
  int stall_mode   = 0;
  int stall_window = 0;
  int stall_phase  = 0;
  always @(posedge clk_i) begin
    if (stall_window == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_window = $urandom_range(10, 120);
    end else begin
      stall_window--;
    end
    stall_phase = (stall_phase + 1) % 5;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 9) < 3);
      2:       out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= (stall_phase < 2);
    endcase
  end

  // Check each result beat against the oldest pending one; watch for a hang.
  always @(posedge clk_i) begin : result_check
    set_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", status_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (was_present_o !== want.was_present)
            report_mismatch("was_present", was_present_o, want.was_present);
          if (element_count_o !== want.count)
            report_mismatch("element_count", element_count_o, want.count);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] value;
    set_result_t        typed_result;
    int                 r;
    int                 phase_left;
    bit                 growing;

    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;

    // Hold reset, then release on a clock edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (directed_rows[row]) begin
      for (int k = 0; k < directed_rows[row].reps; k++) begin
        typed_result.status      = directed_rows[row].status;
        typed_result.was_present = directed_rows[row].was_present;
        typed_result.count       = directed_rows[row].count;
        send_item(directed_rows[row].op, directed_rows[row].value + k,
                  directed_rows[row].typed, typed_result);
        pace();
      end
    end

    // Random part: alternate growing and shrinking phases so the set fills and drains.
    growing    = 1'b1;
    phase_left = $urandom_range(20, 80);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        growing    = !growing;
        phase_left = $urandom_range(20, 80);
      end else begin
        phase_left--;
      end
      if ($urandom_range(0, 49) == 0) value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      r = $urandom_range(0, 99);
      if (r < 5)                          op = CMD_SPARE;
      else if (r < 25)                    op = CMD_QUERY;
      else if (r < (growing ? 80 : 45))   op = CMD_INSERT;
      else                                op = CMD_DELETE;
      value = pick_value(op != CMD_INSERT);
      send_item(op, value, 1'b0, '0);
      pace();
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then give the block time to show stray beats.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
